// ----- sv/infix_to_prefix_converter_assert.svh -----
// Assertion macros shared by the converter RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef INFIX_TO_PREFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_PREFIX_CONVERTER_ASSERT_SVH

// same-cycle implication
`define IPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/ipc_pkg.sv -----
// Package for the infix to prefix converter: sizes, character codes,
// payload structs, stack control struct, state enum, precedence function.
package ipc_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic [7:0] CH_EQ     = 8'h3D; // '='
	localparam logic [7:0] CH_PLUS   = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS  = 8'h2D; // '-'
	localparam logic [7:0] CH_STAR   = 8'h2A; // '*'
	localparam logic [7:0] CH_SLASH  = 8'h2F; // '/'
	localparam logic [7:0] CH_CARET  = 8'h5E; // '^'
	localparam logic [7:0] CH_LPAREN = 8'h28; // '('
	localparam logic [7:0] CH_RPAREN = 8'h29; // ')'
	localparam logic [7:0] CH_A      = 8'h61; // 'a'
	localparam logic [7:0] CH_Z      = 8'h7A; // 'z'

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_expression;
	} ipc_in_t;

	typedef struct packed {
		logic [7:0] prefix_symbol;
		logic       final_symbol;
		logic       error_flag;
	} ipc_out_t;

	// shift control for one chain of cells
	typedef struct packed {
		logic push;
		logic pop;
	} ipc_stk_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} ipc_state_t;

	function automatic logic [1:0] prec(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		case (c) inside
			CH_EQ:              p = 2'd0;
			CH_PLUS, CH_MINUS:  p = 2'd1;
			CH_STAR, CH_SLASH:  p = 2'd2;
			CH_CARET:           p = 2'd3;
			default:            p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

// ----- sv/ipc_cell.sv -----
// One stack cell: holds a character, shifts down on push, up on pop.
// Depends on ipc_pkg.
module ipc_cell (
	input  logic                  clk,
	input  ipc_pkg::ipc_stk_ctl_t ctl,
	input  logic [7:0]            above,
	input  logic [7:0]            below,
	output logic [7:0]            q
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= above;
		end else if (ctl.pop) begin
			data_q <= below;
		end
	end

	assign q = data_q;

endmodule

// ----- sv/ipc_stack.sv -----
// LIFO built as a chain of ipc_cell; cell 0 is the top of stack.
// Depends on ipc_pkg and ipc_cell.
module ipc_stack (
	input  logic                  clk,
	input  ipc_pkg::ipc_stk_ctl_t ctl,
	input  logic [7:0]            din,
	output logic [7:0]            top
);

	logic [7:0] cell_q [ipc_pkg::DEPTH];

	for (genvar i = 0; i < ipc_pkg::DEPTH; i++) begin : g_cell
		logic [7:0] above;
		logic [7:0] below;
		if (i == 0) begin : g_first
			assign above = din;
		end else begin : g_mid
			assign above = cell_q[i-1];
		end
		if (i == ipc_pkg::DEPTH - 1) begin : g_last
			assign below = 8'h00;
		end else begin : g_inner
			assign below = cell_q[i+1];
		end
		ipc_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.above (above),
			.below (below),
			.q     (cell_q[i])
		);
	end

	assign top = cell_q[0];

endmodule

// ----- sv/infix_to_prefix_converter.sv -----
// Infix to prefix converter: three cell-chain stacks (expression, operator, output).
// Load pushes each accepted character onto the expression buffer; the scan then
// pops it right to left into the operator and output stacks, drain empties the
// operator stack into the output stack, and emit pops the output stack as results.
// Requests are refused while an expression is converted; the last result waits in
// the output register while the next expression loads. arst_n clears counts, state, error.
module infix_to_prefix_converter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  ipc_pkg::ipc_in_t  sym,
	output logic              pfx_valid,
	input  logic              pfx_ready,
	output ipc_pkg::ipc_out_t pfx
);

	// Fill counts; payload of the stacks lives in the cell chains.
	ipc_pkg::ipc_state_t           state_q, state_d;
	logic [ipc_pkg::CNT_W-1:0]     len_q, op_top_q, os_top_q;
	logic                          err_q;

	ipc_pkg::ipc_stk_ctl_t buf_ctl, op_ctl, os_ctl;
	logic [7:0]            buf_din, op_din, os_din;
	logic [7:0]            buf_top, op_top_val, os_top_val;
	logic                  err_set;

	logic                  accept, issue, done;
	logic [7:0]            c;
	logic                  is_letter, op_nonempty, op_blocked, op_higher;
	logic                  buf_full, op_full, os_full;

	logic                  pfx_valid_q;
	ipc_pkg::ipc_out_t     pfx_q, pfx_d;

	// Expression buffer: last stored character sits on top, so popping it
	// walks the expression right to left.
	ipc_stack u_buf (.clk(clk), .ctl(buf_ctl), .din(buf_din), .top(buf_top));
	ipc_stack u_op  (.clk(clk), .ctl(op_ctl),  .din(op_din),  .top(op_top_val));
	// Output stack pops top first, which is the prefix order.
	ipc_stack u_os  (.clk(clk), .ctl(os_ctl),  .din(os_din),  .top(os_top_val));

	assign c           = buf_top;
	assign is_letter   = (c >= ipc_pkg::CH_A) && (c <= ipc_pkg::CH_Z);
	assign op_nonempty = (op_top_q != '0);
	assign op_blocked  = (op_top_val == ipc_pkg::CH_RPAREN);
	assign op_higher   = ipc_pkg::prec(op_top_val) > ipc_pkg::prec(c);
	assign buf_full    = (len_q == ipc_pkg::FULL_CNT);
	assign op_full     = (op_top_q == ipc_pkg::FULL_CNT);
	assign os_full     = (os_top_q == ipc_pkg::FULL_CNT);

	assign sym_ready = (state_q == ipc_pkg::ST_LOAD);
	assign accept    = sym_valid && sym_ready;
	assign issue     = (state_q == ipc_pkg::ST_EMIT) && (!pfx_valid_q || pfx_ready);
	// last result when at most one symbol is left (none: the empty result)
	assign done      = issue && (os_top_q <= ipc_pkg::CNT_W'(1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ipc_pkg::ST_LOAD: begin
				if (accept && sym.end_of_expression) state_d = ipc_pkg::ST_SCAN;
			end
			ipc_pkg::ST_SCAN: begin
				if (len_q == '0) state_d = ipc_pkg::ST_DRAIN;
			end
			ipc_pkg::ST_DRAIN: begin
				if (!op_nonempty) state_d = ipc_pkg::ST_EMIT;
			end
			ipc_pkg::ST_EMIT: begin
				if (done) state_d = ipc_pkg::ST_LOAD;
			end
			default: state_d = ipc_pkg::ST_LOAD;
		endcase
	end

	// Stack moves, one decision per cycle
	always_comb begin
		buf_ctl = '0;
		op_ctl  = '0;
		os_ctl  = '0;
		buf_din = sym.symbol;
		op_din  = c;
		os_din  = is_letter ? c : op_top_val;
		err_set = 1'b0;
		pfx_d.prefix_symbol = (os_top_q != '0) ? os_top_val : 8'h00;
		pfx_d.final_symbol  = done;
		pfx_d.error_flag    = err_q;
		unique case (state_q)
			ipc_pkg::ST_LOAD: begin
				if (accept) begin
					// a character beyond the buffer is dropped
					if (buf_full) err_set = 1'b1;
					else buf_ctl.push = 1'b1;
				end
			end
			ipc_pkg::ST_SCAN: begin
				if (len_q != '0) begin
					if (is_letter) begin
						buf_ctl.pop = 1'b1;
						if (os_full) err_set = 1'b1;
						else os_ctl.push = 1'b1;
					end else if (c == ipc_pkg::CH_RPAREN) begin
						buf_ctl.pop = 1'b1;
						if (op_full) err_set = 1'b1;
						else op_ctl.push = 1'b1;
					end else if (c == ipc_pkg::CH_LPAREN) begin
						if (op_nonempty && !op_blocked) begin
							// move one operator, keep '(' for the next cycle
							op_ctl.pop = 1'b1;
							if (os_full) err_set = 1'b1;
							else os_ctl.push = 1'b1;
						end else if (!op_nonempty) begin
							// '(' without its ')'
							err_set     = 1'b1;
							buf_ctl.pop = 1'b1;
						end else begin
							// matching ')' is discarded
							op_ctl.pop  = 1'b1;
							buf_ctl.pop = 1'b1;
						end
					end else begin
						if (op_nonempty && !op_blocked && op_higher) begin
							op_ctl.pop = 1'b1;
							if (os_full) err_set = 1'b1;
							else os_ctl.push = 1'b1;
						end else begin
							buf_ctl.pop = 1'b1;
							if (op_full) err_set = 1'b1;
							else op_ctl.push = 1'b1;
						end
					end
				end
			end
			ipc_pkg::ST_DRAIN: begin
				if (op_nonempty) begin
					op_ctl.pop = 1'b1;
					// a leftover ')' has no '(' and is dropped
					if (op_blocked) err_set = 1'b1;
					else if (os_full) err_set = 1'b1;
					else os_ctl.push = 1'b1;
				end
			end
			ipc_pkg::ST_EMIT: begin
				if (issue && (os_top_q != '0)) os_ctl.pop = 1'b1;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ipc_pkg::ST_LOAD;
			len_q       <= '0;
			op_top_q    <= '0;
			os_top_q    <= '0;
			err_q       <= 1'b0;
			pfx_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (buf_ctl.push) len_q <= len_q + ipc_pkg::CNT_W'(1);
			else if (buf_ctl.pop) len_q <= len_q - ipc_pkg::CNT_W'(1);
			if (op_ctl.push) op_top_q <= op_top_q + ipc_pkg::CNT_W'(1);
			else if (op_ctl.pop) op_top_q <= op_top_q - ipc_pkg::CNT_W'(1);
			if (os_ctl.push) os_top_q <= os_top_q + ipc_pkg::CNT_W'(1);
			else if (os_ctl.pop) os_top_q <= os_top_q - ipc_pkg::CNT_W'(1);
			// error lives for one expression
			if (done) err_q <= 1'b0;
			else if (err_set) err_q <= 1'b1;
			if (issue) pfx_valid_q <= 1'b1;
			else if (pfx_ready) pfx_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (issue) pfx_q <= pfx_d;
	end

	assign pfx_valid = pfx_valid_q;
	assign pfx       = pfx_q;

`include "infix_to_prefix_converter_assert.svh"

	`IPC_ASSERT_NOW(a_busy_no_req, state_q != ipc_pkg::ST_LOAD, !sym_ready, "request taken while busy")
	`IPC_ASSERT_NOW(a_emit_drained, state_q == ipc_pkg::ST_EMIT, (len_q == '0) && (op_top_q == '0), "stacks not drained at emit")
	`IPC_ASSERT_NEXT(a_final_clears, done, (state_q == ipc_pkg::ST_LOAD) && !err_q && (os_top_q == '0), "state not cleared after last result")
	`IPC_ASSERT_NOW(a_count_bound, 1'b1, (len_q <= ipc_pkg::FULL_CNT) && (op_top_q <= ipc_pkg::FULL_CNT) && (os_top_q <= ipc_pkg::FULL_CNT), "stack count beyond depth")

endmodule

// ----- test/infix_to_prefix_converter_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for infix_to_prefix_converter: directed table plus random expressions,
// with results predicted in-bench. Depends on ipc_pkg and the converter RTL only.

module infix_to_prefix_converter_test;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [7:0]        ch;
		logic              last;
		logic              typed;
		ipc_pkg::ipc_out_t want;
	} row_t;

	localparam int RANDOM_ITEMS = 205;
	localparam int TAIL_CYCLES  = 300;    // room for a full scan after the last result

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               sym_valid = 1'b0;
	logic               sym_ready;
	ipc_pkg::ipc_in_t   sym       = '0;
	logic               pfx_valid;
	logic               pfx_ready = 1'b0;
	ipc_pkg::ipc_out_t  pfx;

	// predictor state: characters held for the current expression and its error bit
	logic [7:0] held_chars[$];
	logic       held_err = 1'b0;
	logic [7:0] op_stack[$];
	logic [7:0] out_stack[$];

	ipc_pkg::ipc_out_t prefix_expected[$];
	logic [7:0] draft[$];                 // expression being built for the next burst of requests
	int         burst_left = 0;
	int         mismatches = 0;

	// receiver stall pattern
	logic [7:0] stall_mask = 8'hFF;
	logic [2:0] beat = '0;
	int         phase_left = 0;

	// Directed rows: single characters at the extremes and both lone parentheses (their
	// results are typed in), then one expression with every operator and nesting, then
	// an opening parenthesis that never gets closed.
	row_t directed_rows [0:24] = '{
		'{ipc_pkg::CH_A,         1'b1, 1'b1, '{ipc_pkg::CH_A, 1'b1, 1'b0}},
		'{ipc_pkg::CH_Z,         1'b1, 1'b1, '{ipc_pkg::CH_Z, 1'b1, 1'b0}},
		'{8'h00,                 1'b1, 1'b1, '{8'h00, 1'b1, 1'b0}},
		'{8'hFF,                 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{ipc_pkg::CH_RPAREN,    1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{ipc_pkg::CH_LPAREN,    1'b1, 1'b1, '{8'h00, 1'b1, 1'b1}},
		'{ipc_pkg::CH_LPAREN,    1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A,         1'b0, 1'b0, '0},
		'{ipc_pkg::CH_MINUS,     1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd1,  1'b0, 1'b0, '0},
		'{ipc_pkg::CH_RPAREN,    1'b0, 1'b0, '0},
		'{ipc_pkg::CH_SLASH,     1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd2,  1'b0, 1'b0, '0},
		'{ipc_pkg::CH_CARET,     1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd3,  1'b0, 1'b0, '0},
		'{ipc_pkg::CH_EQ,        1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd4,  1'b0, 1'b0, '0},
		'{ipc_pkg::CH_PLUS,      1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd5,  1'b0, 1'b0, '0},
		'{ipc_pkg::CH_STAR,      1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd6,  1'b1, 1'b0, '0},
		'{ipc_pkg::CH_A,         1'b0, 1'b0, '0},
		'{ipc_pkg::CH_STAR,      1'b0, 1'b0, '0},
		'{ipc_pkg::CH_LPAREN,    1'b0, 1'b0, '0},
		'{ipc_pkg::CH_A + 8'd1,  1'b1, 1'b0, '0}
	};

	infix_to_prefix_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym       (sym),
		.pfx_valid (pfx_valid),
		.pfx_ready (pfx_ready),
		.pfx       (pfx)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs or drops results
	initial begin
		#1000000;
		$display("infix_to_prefix_converter test failed");
		$finish;
	end

	// --------------------------------------------------------------------
	// Predictor
	// --------------------------------------------------------------------

	// operator binding strength; '=' and every unknown character bind weakest
	function automatic int unsigned rank(input logic [7:0] c);
		case (c) inside
			ipc_pkg::CH_PLUS, ipc_pkg::CH_MINUS: return 1;
			ipc_pkg::CH_STAR, ipc_pkg::CH_SLASH: return 2;
			ipc_pkg::CH_CARET:                   return 3;
			default:                             return 0;
		endcase
	endfunction

	function automatic void push_out(input logic [7:0] c);
		if (out_stack.size() < ipc_pkg::DEPTH) out_stack.push_back(c);
		else held_err = 1'b1;
	endfunction

	function automatic void push_op(input logic [7:0] c);
		if (op_stack.size() < ipc_pkg::DEPTH) op_stack.push_back(c);
		else held_err = 1'b1;
	endfunction

	// Right-to-left scan of the held expression. The prefix form is the output stack
	// read from the top; a typed row replaces the computed result with its own.
	function automatic void convert_held(input logic typed, input ipc_pkg::ipc_out_t want);
		int i;
		int n;
		logic [7:0] c;
		ipc_pkg::ipc_out_t r;
		op_stack.delete();
		out_stack.delete();
		for (i = held_chars.size() - 1; i >= 0; i--) begin
			c = held_chars[i];
			if (c >= ipc_pkg::CH_A && c <= ipc_pkg::CH_Z) begin
				push_out(c);
			end else if (c == ipc_pkg::CH_RPAREN) begin
				push_op(c);
			end else if (c == ipc_pkg::CH_LPAREN) begin
				while (op_stack.size() > 0 && op_stack[$] != ipc_pkg::CH_RPAREN)
					push_out(op_stack.pop_back());
				// '(' with no ')' to its right
				if (op_stack.size() == 0) held_err = 1'b1;
				else void'(op_stack.pop_back());
			end else begin
				while (op_stack.size() > 0 && op_stack[$] != ipc_pkg::CH_RPAREN &&
						rank(op_stack[$]) > rank(c))
					push_out(op_stack.pop_back());
				push_op(c);
			end
		end
		// leftover ')' never met its '(' and is dropped with an error
		while (op_stack.size() > 0) begin
			c = op_stack.pop_back();
			if (c == ipc_pkg::CH_RPAREN) held_err = 1'b1;
			else push_out(c);
		end
		n = out_stack.size();
		if (typed) begin
			prefix_expected.push_back(want);
		end else if (n == 0) begin
			// nothing reached the output: a single empty result
			prefix_expected.push_back('{8'h00, 1'b1, held_err});
		end else begin
			for (i = 0; i < n; i++) begin
				r.prefix_symbol = out_stack[n - 1 - i];
				r.final_symbol  = (i == n - 1);
				r.error_flag    = held_err;
				prefix_expected.push_back(r);
			end
		end
		held_chars.delete();
		held_err = 1'b0;
	endfunction

	// one accepted request; characters beyond DEPTH are dropped and flag the expression
	function automatic void take_symbol(input logic [7:0] ch, input logic last,
			input logic typed, input ipc_pkg::ipc_out_t want);
		if (held_chars.size() < ipc_pkg::DEPTH) held_chars.push_back(ch);
		else held_err = 1'b1;
		if (last) convert_held(typed, want);
	endfunction

	// --------------------------------------------------------------------
	// Request side: bursts of random length separated by random gaps
	// --------------------------------------------------------------------

	task automatic send_symbol(input logic [7:0] ch, input logic last, input logic typed,
			input ipc_pkg::ipc_out_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			// about a third of the bursts follow the previous one back to back
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				sym_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sym_valid <= 1'b1;
		sym <= '{symbol: ch, end_of_expression: last};
		do @(posedge clk); while (!sym_ready);
		take_symbol(ch, last, typed, want);
	endtask

	task automatic send_draft();
		int i;
		for (i = 0; i < draft.size(); i++)
			send_symbol(draft[i], i == draft.size() - 1, 1'b0, '0);
	endtask

	function automatic logic [7:0] any_letter();
		return ipc_pkg::CH_A + 8'($urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] any_operator();
		case ($urandom_range(0, 5))
			0:       return ipc_pkg::CH_EQ;
			1:       return ipc_pkg::CH_PLUS;
			2:       return ipc_pkg::CH_MINUS;
			3:       return ipc_pkg::CH_STAR;
			4:       return ipc_pkg::CH_SLASH;
			default: return ipc_pkg::CH_CARET;
		endcase
	endfunction

	// operand (op operand)* with random parenthesized groups, always balanced
	function automatic void make_well_formed();
		int k;
		int operands;
		int depth;
		operands = $urandom_range(1, 7);
		depth = 0;
		for (k = 0; k < operands; k++) begin
			if (k > 0) draft.push_back(any_operator());
			while (depth < 3 && $urandom_range(0, 3) == 0) begin
				draft.push_back(ipc_pkg::CH_LPAREN);
				depth++;
			end
			draft.push_back(any_letter());
			while (depth > 0 && $urandom_range(0, 2) == 0) begin
				draft.push_back(ipc_pkg::CH_RPAREN);
				depth--;
			end
		end
		while (depth > 0) begin
			draft.push_back(ipc_pkg::CH_RPAREN);
			depth--;
		end
	endfunction

	// long expression of mixed tokens, used to fill and overrun the buffer
	function automatic void fill_tokens(input int len);
		int k;
		for (k = 0; k < len; k++) begin
			case ($urandom_range(0, 9)) inside
				0:       draft.push_back(ipc_pkg::CH_LPAREN);
				1:       draft.push_back(ipc_pkg::CH_RPAREN);
				[2:4]:   draft.push_back(any_operator());
				default: draft.push_back(any_letter());
			endcase
		end
	endfunction

	// --------------------------------------------------------------------
	// Result side: ready follows a random mask, re-chosen at the end of each random-length phase;
	// some phases never stall. Every accepted result is checked against the
	// oldest prediction.
	// --------------------------------------------------------------------

	always @(posedge clk) begin
		ipc_pkg::ipc_out_t want;
		if (pfx_valid && pfx_ready) begin
			if (prefix_expected.size() == 0) begin
				$display("%0t: unexpected result symbol=%h final=%b error=%b",
					$time, pfx.prefix_symbol, pfx.final_symbol, pfx.error_flag);
				mismatches++;
			end else begin
				want = prefix_expected.pop_front();
				if (pfx.prefix_symbol !== want.prefix_symbol ||
						pfx.final_symbol !== want.final_symbol ||
						pfx.error_flag !== want.error_flag) begin
					$display("%0t: expected symbol=%h final=%b error=%b, got symbol=%h final=%b error=%b",
						$time, want.prefix_symbol, want.final_symbol, want.error_flag,
						pfx.prefix_symbol, pfx.final_symbol, pfx.error_flag);
					mismatches++;
				end
			end
		end
		if (phase_left == 0) begin
			phase_left <= $urandom_range(16, 96);
			case ($urandom_range(0, 3))
				0:       stall_mask <= 8'hFF;
				1:       stall_mask <= 8'($urandom) | 8'h01;
				default: stall_mask <= 8'($urandom);
			endcase
		end else begin
			phase_left <= phase_left - 1;
		end
		beat <= beat + 3'd1;
		pfx_ready <= stall_mask[beat];
	end

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------

	initial begin
		int i;
		int sent;
		int expr_no;
		int idx;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(directed_rows); i++)
			send_symbol(directed_rows[i].ch, directed_rows[i].last,
				directed_rows[i].typed, directed_rows[i].want);

		// Random part: mostly well-formed expressions, with broken parentheses, raw
		// bytes and swapped characters mixed in. One expression fills the buffer exactly
		// and one runs past its end.
		sent = 0;
		expr_no = 0;
		while (sent < RANDOM_ITEMS) begin
			draft.delete();
			if (expr_no == 3) begin
				fill_tokens(ipc_pkg::DEPTH);
			end else if (expr_no == 7) begin
				fill_tokens(ipc_pkg::DEPTH + 2);
			end else begin
				case ($urandom_range(0, 9))
					6: begin
						// insert or drop one parenthesis
						make_well_formed();
						idx = $urandom_range(0, draft.size() - 1);
						if (draft[idx] == ipc_pkg::CH_LPAREN || draft[idx] == ipc_pkg::CH_RPAREN)
							draft.delete(idx);
						else
							draft.insert(idx, $urandom_range(0, 1) ?
								ipc_pkg::CH_LPAREN : ipc_pkg::CH_RPAREN);
						if (draft.size() == 0) draft.push_back(ipc_pkg::CH_RPAREN);
					end
					7: begin
						// raw bytes over the whole code range
						for (idx = $urandom_range(1, 8); idx > 0; idx--)
							draft.push_back(8'($urandom_range(0, 255)));
					end
					8: begin
						// one character swapped for any byte
						make_well_formed();
						draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom);
					end
					default: make_well_formed();
				endcase
			end
			send_draft();
			sent += draft.size();
			expr_no++;
		end
		sym_valid <= 1'b0;

		while (prefix_expected.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("infix_to_prefix_converter test passed");
		else
			$display("infix_to_prefix_converter test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/ipc_pkg.sv
sv/ipc_cell.sv
sv/ipc_stack.sv
sv/infix_to_prefix_converter.sv
test/infix_to_prefix_converter_test.sv
